[src/sbo_pkg.sv]
package sbo_pkg;

  // Default depth of the header store.
  localparam int unsigned StoreBytesDef = 256;

  // Configuration port
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic        RegSelectTimeout = 1'b0;  // register index, paddr[2]
  localparam logic [31:0] TimeoutRst = 32'd5000;

  // Request actions
  localparam logic [1:0] ActSelect  = 2'd0;
  localparam logic [1:0] ActOperate = 2'd1;
  localparam logic [1:0] ActClear   = 2'd2;
  localparam logic [1:0] ActNone    = 2'd3;

  // Request kind, taken from the first byte
  localparam logic KindSelect  = 1'b0;
  localparam logic KindOperate = 1'b1;

  // Mode
  localparam logic [1:0] ModeIdle     = 2'd0;
  localparam logic [1:0] ModeSelected = 2'd1;
  localparam logic [1:0] ModeOperated = 2'd2;

  // Status
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StRepeat  = 3'd1;
  localparam logic [2:0] StParam   = 3'd2;
  localparam logic [2:0] StNoSel   = 3'd3;
  localparam logic [2:0] StTimeout = 3'd4;

  localparam logic [3:0] SeqRst = 4'hF;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  sequence_req;
    logic [31:0] now_ms;
    logic [7:0]  header_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] mode_after;
  } out_item_t;

  // Per-byte flags handed from the byte tracker to the decision stage.
  typedef struct packed {
    logic clear;
    logic kind;
    logic in_range;
    logic last;
  } trk_t;

endpackage

[src/select_before_operate_guard.sv]
// Select-before-operate guard.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// request byte; the action of the first byte sets the request kind, and the
// byte with last_byte set closes the request. A clear acts on any byte.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transaction
// per closed request or clear, carrying status and the mode after it.
// Configuration: APB-style port, select_timeout_ms at byte address 0.
// Timing: one byte per cycle sustained while the output is not stalled. A
// closing byte's result passes the synchronous header-store read and then
// the output register. The store is read and written in the same
// cycle (read-first), so each byte needs a single store port access.
// Stall: while the output register holds an untaken result, the whole
// pipeline freezes and in_stall_o rises; nothing is lost or duplicated.
// Reset: mode idle, stored sequence 15, timeout 5000 ms, no request in
// flight. The header store is not cleared; a select writes the entries it
// covers, and entries at or past the stored length compare as a mismatch.
module select_before_operate_guard #(
  parameter int unsigned StoreBytes = sbo_pkg::StoreBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sbo_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sbo_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbo_pkg::PaddrW-1:0]  paddr,
  input  logic [sbo_pkg::PdataW-1:0]  pwdata,
  output logic [sbo_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import sbo_pkg::*;

  localparam int unsigned CntW  = $clog2(StoreBytes + 1);
  localparam int unsigned AddrW = $clog2(StoreBytes);

  // Configuration register
  logic [31:0] timeout_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegSelectTimeout)) begin
      timeout_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == RegSelectTimeout) ? timeout_q : '0;

  // Pipeline control: advance everything when the output slot is free.
  logic advance, accept;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // Stage 0: byte tracking and store access
  trk_t            trk;
  logic [CntW-1:0] idx;
  logic            mem_en, mem_we;
  logic [7:0]      rdata;

  sbo_track #(
    .StoreBytes (StoreBytes),
    .CntW       (CntW)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .action_i (in_data_i.action),
    .last_i   (in_data_i.last_byte),
    .trk_o    (trk),
    .idx_o    (idx),
    .mem_en_o (mem_en),
    .mem_we_o (mem_we)
  );

  sbo_hdr_mem #(
    .StoreBytes (StoreBytes)
  ) u_hdr_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (idx[AddrW-1:0]),
    .wdata_i (in_data_i.header_byte),
    .rdata_o (rdata)
  );

  // Stage 1 registers: hold the byte while its store read completes.
  logic            s1_valid_q;
  trk_t            s1_trk_q;
  logic [CntW-1:0] s1_idx_q;
  logic [7:0]      s1_byte_q;
  logic [3:0]      s1_seq_q;
  logic [31:0]     s1_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept && (in_data_i.action != ActNone);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_trk_q  <= trk;
      s1_idx_q  <= idx;
      s1_byte_q <= in_data_i.header_byte;
      s1_seq_q  <= in_data_i.sequence_req;
      s1_now_q  <= in_data_i.now_ms;
    end
  end

  // Stage 1: compare, decide at the closing byte, update the guard state.
  logic      res_valid;
  out_item_t res;

  sbo_decide #(
    .StoreBytes (StoreBytes),
    .CntW       (CntW)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .advance_i   (advance),
    .trk_i       (s1_trk_q),
    .idx_i       (s1_idx_q),
    .rdata_i     (rdata),
    .byte_i      (s1_byte_q),
    .seq_i       (s1_seq_q),
    .now_i       (s1_now_q),
    .timeout_i   (timeout_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A repeat only happens while selected or operated, so it never reports idle.
  a_repeat_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StRepeat))
      |-> (out_data_o.mode_after != ModeIdle))
    else $error("repeat reported with the guard idle");

  // Timeout and parameter errors always drop the guard to idle.
  a_fail_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_data_o.status == StTimeout) || (out_data_o.status == StParam)))
      |-> (out_data_o.mode_after == ModeIdle))
    else $error("timeout or parameter error without return to idle");

  // An accepted clear enters stage 1 on the next edge.
  a_clear_flows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.action == ActClear)) |=> (s1_valid_q && s1_trk_q.clear))
    else $error("accepted clear lost before stage 1");

  // A clear always reports ok and idle.
  a_clear_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && s1_trk_q.clear)
      |=> (out_valid_o && (out_data_o.status == StOk) && (out_data_o.mode_after == ModeIdle)))
    else $error("clear did not report ok and idle");

endmodule

[src/sbo_hdr_mem.sv]
module sbo_hdr_mem #(
  parameter int unsigned StoreBytes = 256
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [$clog2(StoreBytes)-1:0] addr_i,
  input  logic [7:0]                    wdata_i,
  output logic [7:0]                    rdata_o
);

  logic [7:0] mem [StoreBytes];
  logic [7:0] rdata_q;

  // Read-first: a select byte sees the old entry while overwriting it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sbo_track.sv]
module sbo_track #(
  parameter int unsigned StoreBytes = 256,
  parameter int unsigned CntW       = $clog2(StoreBytes + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           action_i,
  input  logic                 last_i,
  output sbo_pkg::trk_t        trk_o,
  output logic [CntW-1:0]      idx_o,
  output logic                 mem_en_o,
  output logic                 mem_we_o
);
  import sbo_pkg::*;

  localparam logic [CntW-1:0] Depth = CntW'(StoreBytes);

  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            kind_q, kind_d;
  logic            kind_eff;
  logic            in_range;
  logic            byte_item;

  assign byte_item = (action_i == ActSelect) || (action_i == ActOperate);
  assign in_range  = byte_count_q < Depth;
  assign kind_eff  = (byte_count_q == '0)
                   ? ((action_i == ActOperate) ? KindOperate : KindSelect)
                   : kind_q;

  always_comb begin
    byte_count_d = byte_count_q;
    kind_d       = kind_q;
    if (accept_i) begin
      if (action_i == ActClear) begin
        byte_count_d = '0;
        kind_d       = KindSelect;
      end else if (byte_item) begin
        kind_d = kind_eff;
        if (last_i) begin
          byte_count_d = '0;
        end else if (in_range) begin
          byte_count_d = byte_count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      kind_q       <= KindSelect;
    end else begin
      byte_count_q <= byte_count_d;
      kind_q       <= kind_d;
    end
  end

  assign trk_o.clear    = (action_i == ActClear);
  assign trk_o.kind     = kind_eff;
  assign trk_o.in_range = in_range;
  assign trk_o.last     = last_i;
  assign idx_o          = byte_count_q;
  assign mem_en_o       = accept_i && byte_item && in_range;
  assign mem_we_o       = accept_i && byte_item && in_range && (kind_eff == KindSelect);

endmodule

[src/sbo_decide.sv]
module sbo_decide #(
  parameter int unsigned StoreBytes = 256,
  parameter int unsigned CntW       = $clog2(StoreBytes + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  advance_i,
  input  sbo_pkg::trk_t         trk_i,
  input  logic [CntW-1:0]       idx_i,
  input  logic [7:0]            rdata_i,
  input  logic [7:0]            byte_i,
  input  logic [3:0]            seq_i,
  input  logic [31:0]           now_i,
  input  logic [31:0]           timeout_i,
  output logic                  res_valid_o,
  output sbo_pkg::out_item_t    res_o
);
  import sbo_pkg::*;

  logic [1:0]      mode_q, mode_d;
  logic [3:0]      seq_q, seq_d;
  logic [31:0]     sel_time_q, sel_time_d;
  logic [CntW-1:0] len_q, len_d;
  logic            mm_q, mm_d;
  logic            ov_q, ov_d;

  logic            mm_now, ov_now, equal, good_seq;
  logic [CntW-1:0] count;
  logic [31:0]     elapsed;
  logic [2:0]      status;

  assign mm_now   = mm_q || (trk_i.in_range && ((idx_i >= len_q) || (rdata_i != byte_i)));
  assign ov_now   = ov_q || !trk_i.in_range;
  assign count    = idx_i + CntW'(1);
  assign equal    = !ov_now && !mm_now && (count == len_q);
  assign good_seq = (seq_i == (seq_q + 4'd1));
  assign elapsed  = now_i - sel_time_q;

  always_comb begin
    mode_d     = mode_q;
    seq_d      = seq_q;
    sel_time_d = sel_time_q;
    len_d      = len_q;
    mm_d       = mm_q;
    ov_d       = ov_q;
    status     = StOk;
    if (valid_i && advance_i) begin
      if (trk_i.clear) begin
        mode_d = ModeIdle;
        mm_d   = 1'b0;
        ov_d   = 1'b0;
      end else if (!trk_i.last) begin
        mm_d = mm_now;
        ov_d = ov_now;
      end else begin
        mm_d = 1'b0;
        ov_d = 1'b0;
        if (trk_i.kind == KindSelect) begin
          if ((mode_q == ModeSelected) && (seq_i == seq_q)) begin
            if (equal) begin
              status = StRepeat;
            end else begin
              status = StParam;
              mode_d = ModeIdle;
            end
          end else if (ov_now) begin
            status = StParam;
            mode_d = ModeIdle;
          end else begin
            status     = StOk;
            sel_time_d = now_i;
            mode_d     = ModeSelected;
            seq_d      = seq_i;
            len_d      = count;
          end
        end else begin
          if (mode_q == ModeSelected) begin
            if (equal && good_seq) begin
              if (elapsed > timeout_i) begin
                status = StTimeout;
                mode_d = ModeIdle;
              end else begin
                status = StOk;
                mode_d = ModeOperated;
              end
            end else begin
              status = StNoSel;
              mode_d = ModeIdle;
            end
          end else if (mode_q == ModeOperated) begin
            status = (equal && good_seq) ? StRepeat : StNoSel;
          end else begin
            status = StNoSel;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeIdle;
      seq_q      <= SeqRst;
      sel_time_q <= '0;
      len_q      <= '0;
      mm_q       <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      seq_q      <= seq_d;
      sel_time_q <= sel_time_d;
      len_q      <= len_d;
      mm_q       <= mm_d;
      ov_q       <= ov_d;
    end
  end

  assign res_valid_o      = valid_i && (trk_i.clear || trk_i.last);
  assign res_o.status     = status;
  assign res_o.mode_after = mode_d;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sbo_pkg::*;

  localparam int unsigned StoreBytes = StoreBytesDef;
  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned DrainCycles = 8;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic pready;

  select_before_operate_guard DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow of the guard: armed selection, header copy and the request being
  // collected, plus the programmed select timeout.
  logic [1:0]  guard_mode;
  logic [3:0]  armed_seq;
  logic [31:0] armed_time;
  int unsigned armed_len;
  logic [7:0]  header_copy [StoreBytes];
  int unsigned rx_count;
  logic        rx_mismatch;
  logic        rx_overflow;
  logic        rx_kind;
  logic [31:0] limit_ms;

  // Verdicts (status, mode after) still owed by the guard, oldest first.
  out_item_t   owed_verdicts [$];
  out_item_t   oldest_verdict;

  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int          stall_left;
  logic        gaps_on;
  logic        stalls_on;
  logic [31:0] wall_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drop the partial request and start collecting a fresh one.
  function automatic void restart_request();
    rx_count    = 0;
    rx_mismatch = 1'b0;
    rx_overflow = 1'b0;
    rx_kind     = KindSelect;
  endfunction

  function automatic void reset_guard();
    guard_mode = ModeIdle;
    armed_seq  = SeqRst;
    armed_time = '0;
    armed_len  = 0;
    limit_ms   = TimeoutRst;
    foreach (header_copy[i]) header_copy[i] = '0;
    restart_request();
  endfunction

  // Advance the shadow by one accepted byte; return 1 when it closes a
  // request or clears the guard, with the verdict the guard must give.
  function automatic bit judge_byte(input in_item_t it, output out_item_t verdict);
    logic        same;
    logic        next_ok;
    logic [3:0]  next_seq;
    logic [31:0] elapsed;
    verdict = '0;
    if (it.action == ActNone) return 1'b0;
    if (it.action == ActClear) begin
      guard_mode = ModeIdle;
      restart_request();
      verdict.status     = StOk;
      verdict.mode_after = ModeIdle;
      return 1'b1;
    end
    if (rx_count == 0) rx_kind = (it.action == ActOperate) ? KindOperate : KindSelect;
    if (rx_count < StoreBytes) begin
      if (rx_count >= armed_len || header_copy[rx_count] != it.header_byte) begin
        rx_mismatch = 1'b1;
      end
      if (rx_kind == KindSelect) header_copy[rx_count] = it.header_byte;
      rx_count++;
    end else begin
      rx_overflow = 1'b1;
      rx_count    = StoreBytes + 1;
    end
    if (!it.last_byte) return 1'b0;

    same = !rx_overflow && !rx_mismatch && rx_count == armed_len;
    if (rx_kind == KindSelect) begin
      if (guard_mode == ModeSelected && it.sequence_req == armed_seq) begin
        // Same sequence while armed: a repeat only if the headers match.
        if (same) begin
          verdict.status = StRepeat;
        end else begin
          guard_mode     = ModeIdle;
          verdict.status = StParam;
        end
      end else if (rx_overflow) begin
        guard_mode     = ModeIdle;
        verdict.status = StParam;
      end else begin
        armed_time     = it.now_ms;
        armed_seq      = it.sequence_req;
        armed_len      = rx_count;
        guard_mode     = ModeSelected;
        verdict.status = StOk;
      end
    end else begin
      elapsed  = it.now_ms - armed_time;
      next_seq = armed_seq + 4'd1;
      next_ok  = it.sequence_req == next_seq;
      if (guard_mode == ModeSelected) begin
        if (same && next_ok) begin
          if (elapsed > limit_ms) begin
            guard_mode     = ModeIdle;
            verdict.status = StTimeout;
          end else begin
            guard_mode     = ModeOperated;
            verdict.status = StOk;
          end
        end else begin
          guard_mode     = ModeIdle;
          verdict.status = StNoSel;
        end
      end else if (guard_mode == ModeOperated) begin
        verdict.status = (same && next_ok) ? StRepeat : StNoSel;
      end else begin
        verdict.status = StNoSel;
      end
    end
    restart_request();
    verdict.mode_after = guard_mode;
    return 1'b1;
  endfunction

  // Present one byte, hold it until taken, then record what it owes.
  task automatic send_byte(input in_item_t it);
    out_item_t verdict;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.action != ActNone) bytes_sent++;
    if (judge_byte(it, verdict)) owed_verdicts.push_back(verdict);
  endtask

  // Byte that the guard must ignore entirely.
  task automatic send_noise();
    in_item_t it;
    it.action       = ActNone;
    it.sequence_req = 4'($urandom);
    it.now_ms       = $urandom;
    it.header_byte  = 8'($urandom);
    it.last_byte    = 1'($urandom);
    send_byte(it);
  endtask

  // Send a whole request; clear_at >= 0 replaces that byte with a clear and
  // abandons the rest. Only the final byte carries the real sequence and time.
  task automatic send_request(input logic [1:0] act, input logic [3:0] seq,
                              input logic [31:0] at_ms, input logic [7:0] hdr[$],
                              input int clear_at);
    in_item_t it;
    for (int i = 0; i < hdr.size(); i++) begin
      if ($urandom_range(0, 29) == 0) send_noise();
      it.header_byte = hdr[i];
      it.last_byte   = (i == hdr.size() - 1);
      if (i == 0) begin
        it.action = act;
      end else begin
        it.action = $urandom_range(0, 1) ? ActOperate : ActSelect;
      end
      if (it.last_byte) begin
        it.sequence_req = seq;
        it.now_ms       = at_ms;
      end else begin
        it.sequence_req = 4'($urandom);
        it.now_ms       = $urandom;
      end
      if (i == clear_at) begin
        it.action    = ActClear;
        it.last_byte = 1'($urandom);
        send_byte(it);
        return;
      end
      send_byte(it);
    end
  endtask

  task automatic send_clear();
    in_item_t it;
    it.action       = ActClear;
    it.sequence_req = 4'($urandom);
    it.now_ms       = $urandom;
    it.header_byte  = 8'($urandom);
    it.last_byte    = 1'($urandom);
    send_byte(it);
  endtask

  // Hold off the sender until every owed verdict is in, then let the
  // pipeline drain bytes that owe nothing.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegSelectTimeout, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_ms = value;
  endtask

  function automatic void fill_headers(ref logic [7:0] hdr[$], input int unsigned n);
    hdr.delete();
    repeat (n) hdr.push_back(8'($urandom));
  endfunction

  // Damage a header run: flip a byte, grow it or shorten it.
  function automatic void mutate(ref logic [7:0] hdr[$]);
    int unsigned k;
    case ($urandom_range(0, 2))
      0: begin
        k = $urandom_range(0, hdr.size() - 1);
        hdr[k] ^= 8'($urandom_range(1, 255));
      end
      1: begin
        hdr.push_back(8'($urandom));
      end
      default: begin
        if (hdr.size() > 1) void'(hdr.pop_back());
        else hdr[0] ^= 8'h01;
      end
    endcase
  endfunction

  function automatic int unsigned pick_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
  endfunction

  // Time from select to operate, clustered on the timeout boundary.
  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return limit_ms;
      2:       return limit_ms + 32'd1;
      3:       return limit_ms - 32'd1;
      4:       return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic test_basic();
    logic [7:0] hdr[$];
    hdr = {8'h00};
    send_request(ActOperate, 4'd0, 32'd10, hdr, -1);          // operate while idle
    hdr = {8'hFF, 8'h00};
    send_request(ActSelect, 4'd3, 32'd100, hdr, -1);          // arm
    send_request(ActSelect, 4'd3, 32'd200, hdr, -1);          // repeat select
    send_request(ActOperate, 4'd4, 32'd5100, hdr, -1);        // elapsed right at limit
    send_request(ActOperate, 4'd4, 32'd5150, hdr, -1);        // repeat operate
    send_request(ActOperate, 4'd5, 32'd5200, hdr, -1);        // wrong sequence, stays operated
    send_noise();
    hdr = {8'hAA, 8'hBB};
    send_request(ActSelect, 4'd9, 32'd0, hdr, 1);             // clear mid-request
    hdr = {8'h12};
    send_request(ActSelect, 4'd15, 32'hFFFF_FF00, hdr, -1);
    send_request(ActOperate, 4'd0, 32'h0000_1000, hdr, -1);   // time and sequence wrap
    hdr = {8'h55, 8'h66};
    send_request(ActSelect, 4'd7, 32'hFFFF_FFFF, hdr, -1);
    hdr = {8'h55, 8'h67};
    send_request(ActSelect, 4'd7, 32'd0, hdr, -1);            // repeat with other headers
    hdr = {8'h01};
    send_request(ActSelect, 4'd1, 32'd1000, hdr, -1);
    send_request(ActOperate, 4'd2, 32'd6001, hdr, -1);        // one past the limit
    hdr = {8'h01, 8'h02};
    send_request(ActSelect, 4'd2, 32'd7000, hdr, -1);
    hdr = {8'h01};
    send_request(ActOperate, 4'd3, 32'd7001, hdr, -1);        // short headers
    send_clear();
  endtask

  // Header runs past the store depth.
  task automatic test_overflow();
    logic [7:0] hdr[$];
    fill_headers(hdr, StoreBytes + 1);
    send_request(ActSelect, 4'd5, 32'd20, hdr, -1);
    void'(hdr.pop_back());
    send_request(ActSelect, 4'd5, 32'd30, hdr, -1);
    hdr.push_back(8'($urandom));
    send_request(ActOperate, 4'd6, 32'd40, hdr, -1);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    logic [3:0]  seq;
    logic [7:0]  hdr[$];
    logic [7:0]  alt[$];
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      fill_headers(hdr, pick_length());
      if (pick < 65) begin
        // Well-formed select/operate with random flaws sprinkled in.
        seq = 4'($urandom);
        wall_ms += $urandom_range(0, 50);
        send_request(ActSelect, seq, wall_ms, hdr, -1);
        if ($urandom_range(0, 4) == 0) begin
          alt = hdr;
          if ($urandom_range(0, 2) == 0) mutate(alt);
          send_request(ActSelect, seq, wall_ms + $urandom_range(0, 100), alt, -1);
        end
        alt = hdr;
        if ($urandom_range(0, 9) == 0) mutate(alt);
        if ($urandom_range(0, 9) != 0) seq = seq + 4'd1;
        else seq = 4'($urandom);
        wall_ms += pick_delay();
        send_request(ActOperate, seq, wall_ms,
                     alt, ($urandom_range(0, 19) == 0) ? int'(alt.size()) - 1 : -1);
        if ($urandom_range(0, 3) == 0) begin
          send_request(ActOperate, seq, wall_ms + $urandom_range(0, 10), alt, -1);
        end
      end else if (pick < 85) begin
        send_request($urandom_range(0, 1) ? ActOperate : ActSelect, 4'($urandom),
                     $urandom, hdr,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, hdr.size() - 1) : -1);
      end else if (pick < 92) begin
        send_clear();
      end else begin
        send_noise();
      end
    end
  endtask

  // Run the traffic mix under the extreme timeouts (zero and all ones) and a tiny one.
  task automatic test_timeout_limits();
    settle();
    write_limit(32'd0);
    run_random(190);
    settle();
    gaps_on   = 1'b1;
    stalls_on = 1'b0;
    write_limit(32'hFFFF_FFFF);
    run_random(190);
    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    write_limit($urandom_range(1, 20));
    run_random(190);
  endtask

  // Back to the reset timeout, full rate both ways.
  task automatic test_full_rate();
    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_limit(TimeoutRst);
    run_random(180);
  endtask

  // Random stall bursts on the result side.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest owed verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_verdicts.size() == 0) begin
        $error("unexpected result: status %0d mode_after %0d",
               out_data_o.status, out_data_o.mode_after);
        errors++;
      end else begin
        oldest_verdict = owed_verdicts.pop_front();
        if (out_data_o.status !== oldest_verdict.status) begin
          $error("status: expected %0d, actual %0d", oldest_verdict.status,
                 out_data_o.status);
          errors++;
        end
        if (out_data_o.mode_after !== oldest_verdict.mode_after) begin
          $error("mode_after: expected %0d, actual %0d", oldest_verdict.mode_after,
                 out_data_o.mode_after);
          errors++;
        end
      end
    end
  end

  // Stop a hung run: too long without any transaction on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $error("no transaction for %0d cycles, %0d verdicts owed", quiet_cycles,
               owed_verdicts.size());
        $display("select_before_operate_guard test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    errors       = 0;
    bytes_sent   = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    wall_ms      = $urandom;
    reset_guard();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic();
    test_overflow();
    test_timeout_limits();
    test_full_rate();

    settle();
    if (errors == 0) begin
      $display("select_before_operate_guard test passed");
    end else begin
      $display("select_before_operate_guard test failed");
    end
    $finish;
  end

endmodule
